// ----- rtl/dbdf_pkg.sv -----
`timescale 1ns / 1ps

package dbdf_pkg;

  localparam int NUM_CLASSES = 128;
  localparam int CLASS_AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam int THR_W      = 16;
  localparam int COORD_W    = 24;
  localparam int CLS_IN_W   = 8;
  localparam int NET_W      = 13;
  localparam int FMT_W      = 2;
  localparam int CORNER_W   = 26;
  localparam int PROD_W     = COORD_W + NET_W + 1;
  localparam int OUT_W      = 21;
  localparam int CLASS_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic OP_WR_THR = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [FMT_W-1:0] FMT_CENTER = 2'd0;
  localparam logic [FMT_W-1:0] FMT_CORNER = 2'd1;
  localparam logic [FMT_W-1:0] FMT_NORM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_HEIGHT = 2'd2;

  localparam logic [FMT_W-1:0] FMT_RESET = FMT_CENTER;
  localparam logic [NET_W-1:0] NET_RESET = 13'd640;

  localparam logic [OUT_W-1:0] MIN_SIZE = 21'd256;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [NET_W-1:0] net_w;
    logic [NET_W-1:0] net_h;
  } dbdf_cfg_t;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [CLASS_AW-1:0] addr;
    logic [THR_W-1:0]    wr_data;
  } dbdf_tbl_req_t;

  typedef struct packed {
    logic                     norm;
    logic signed [PROD_W-1:0] xa;
    logic signed [PROD_W-1:0] ya;
    logic signed [PROD_W-1:0] xb;
    logic signed [PROD_W-1:0] yb;
    logic [CLASS_W-1:0]       cls;
    logic [THR_W-1:0]         score;
  } dbdf_s2_t;

endpackage

// ----- rtl/dbdf_ram.sv -----
`timescale 1ns / 1ps

module dbdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dbdf_thr_table.sv -----
`timescale 1ns / 1ps

module dbdf_thr_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dbdf_pkg::dbdf_tbl_req_t req,
  output logic [dbdf_pkg::THR_W-1:0] thr
);
  import dbdf_pkg::*;

  logic [NUM_CLASSES-1:0] vld_r;
  logic                   vld_q_r;
  logic [THR_W-1:0]       ram_q;

  dbdf_ram #(
    .WIDTH (THR_W),
    .DEPTH (NUM_CLASSES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.addr),
    .rd_data (ram_q)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= vld_r[req.addr];
      end
    end
  end

  assign thr = vld_q_r ? ram_q : '0;

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en))
    else $error("threshold table read and write in one cycle");

endmodule

// ----- rtl/dbdf_decode.sv -----
`timescale 1ns / 1ps

module dbdf_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbdf_pkg::dbdf_cfg_t                 cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [dbdf_pkg::THR_W-1:0]          in_score,
  input  logic signed [dbdf_pkg::CLS_IN_W-1:0] in_class_index,
  input  logic signed [dbdf_pkg::COORD_W-1:0] in_coord_a,
  input  logic signed [dbdf_pkg::COORD_W-1:0] in_coord_b,
  input  logic signed [dbdf_pkg::COORD_W-1:0] in_coord_c,
  input  logic signed [dbdf_pkg::COORD_W-1:0] in_coord_d,
  output dbdf_pkg::dbdf_tbl_req_t             tbl_req,
  input  logic [dbdf_pkg::THR_W-1:0]          thr,
  output logic                                s2_valid,
  output dbdf_pkg::dbdf_s2_t                  s2,
  input  logic                                s3_ready
);
  import dbdf_pkg::*;

  function automatic logic signed [PROD_W-1:0] to_q16(input logic signed [CORNER_W-1:0] v);
    logic signed [CORNER_W+7:0] t;
    t = $signed({v, 8'h00});
    return PROD_W'(t);
  endfunction

  logic                        s1_ready;
  logic                        s2_ready;
  logic                        acc;
  logic                        cls_ok;
  logic                        is_dec;

  logic                        s1_v_r;
  logic [THR_W-1:0]            s1_score_r;
  logic [CLASS_W-1:0]          s1_cls_r;
  logic signed [COORD_W-1:0]   s1_a_r;
  logic signed [COORD_W-1:0]   s1_b_r;
  logic signed [COORD_W-1:0]   s1_c_r;
  logic signed [COORD_W-1:0]   s1_d_r;

  logic signed [COORD_W-1:0]   hw;
  logic signed [COORD_W-1:0]   hh;
  logic signed [CORNER_W-1:0]  cx1;
  logic signed [CORNER_W-1:0]  cy1;
  logic signed [CORNER_W-1:0]  cx2;
  logic signed [CORNER_W-1:0]  cy2;
  logic signed [PROD_W-1:0]    pa;
  logic signed [PROD_W-1:0]    pb;
  logic signed [PROD_W-1:0]    pc;
  logic signed [PROD_W-1:0]    pd;
  logic                        fmt_ok;
  logic                        keep;
  dbdf_s2_t                    s2_nxt;

  logic                        s2_v_r;
  dbdf_s2_t                    s2_r;

  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;
  assign acc      = in_valid && s1_ready;

  assign cls_ok = !in_class_index[CLS_IN_W-1] &&
                  ({1'b0, in_class_index[CLASS_W-1:0]} < CLS_IN_W'(NUM_CLASSES));
  assign is_dec = (in_operation == OP_DECODE);

  always_comb begin
    tbl_req.rd_en   = acc && cls_ok && is_dec;
    tbl_req.wr_en   = acc && cls_ok && !is_dec;
    tbl_req.addr    = in_class_index[CLASS_AW-1:0];
    tbl_req.wr_data = in_score;
  end

  // stage 1: candidate beat, threshold read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid && cls_ok && is_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_score_r <= in_score;
      s1_cls_r   <= in_class_index[CLASS_W-1:0];
      s1_a_r     <= in_coord_a;
      s1_b_r     <= in_coord_b;
      s1_c_r     <= in_coord_c;
      s1_d_r     <= in_coord_d;
    end
  end

  always_comb begin
    hw  = s1_c_r >>> 1;
    hh  = s1_d_r >>> 1;
    cx1 = CORNER_W'(s1_a_r) - CORNER_W'(hw);
    cy1 = CORNER_W'(s1_b_r) - CORNER_W'(hh);
    cx2 = cx1 + CORNER_W'(s1_c_r);
    cy2 = cy1 + CORNER_W'(s1_d_r);
    pa  = s1_a_r * $signed({1'b0, cfg.net_w});
    pb  = s1_b_r * $signed({1'b0, cfg.net_h});
    pc  = s1_c_r * $signed({1'b0, cfg.net_w});
    pd  = s1_d_r * $signed({1'b0, cfg.net_h});

    fmt_ok       = 1'b1;
    s2_nxt.norm  = 1'b0;
    s2_nxt.cls   = s1_cls_r;
    s2_nxt.score = s1_score_r;
    s2_nxt.xa    = to_q16(CORNER_W'(s1_a_r));
    s2_nxt.ya    = to_q16(CORNER_W'(s1_b_r));
    s2_nxt.xb    = to_q16(CORNER_W'(s1_c_r));
    s2_nxt.yb    = to_q16(CORNER_W'(s1_d_r));
    case (cfg.fmt)
      FMT_CENTER: begin
        s2_nxt.xa = to_q16(cx1);
        s2_nxt.ya = to_q16(cy1);
        s2_nxt.xb = to_q16(cx2);
        s2_nxt.yb = to_q16(cy2);
      end
      FMT_CORNER: begin
      end
      FMT_NORM: begin
        s2_nxt.norm = 1'b1;
        s2_nxt.xa   = pa;
        s2_nxt.ya   = pb;
        s2_nxt.xb   = pc;
        s2_nxt.yb   = pd;
      end
      default: begin
        fmt_ok = 1'b0;
      end
    endcase
    keep = fmt_ok && (s1_score_r >= thr);
  end

  // stage 2: corners in Q.16, products registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2       = s2_r;

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with stage 1 empty");

endmodule

// ----- rtl/dbdf_clamp.sv -----
`timescale 1ns / 1ps

module dbdf_clamp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbdf_pkg::dbdf_cfg_t           cfg,
  input  logic                          s2_valid,
  input  dbdf_pkg::dbdf_s2_t            s2,
  output logic                          s3_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dbdf_pkg::OUT_W-1:0]    out_box_left,
  output logic [dbdf_pkg::OUT_W-1:0]    out_box_top,
  output logic [dbdf_pkg::OUT_W-1:0]    out_box_width,
  output logic [dbdf_pkg::OUT_W-1:0]    out_box_height,
  output logic [dbdf_pkg::CLASS_W-1:0]  out_class,
  output logic [dbdf_pkg::THR_W-1:0]    out_confidence
);
  import dbdf_pkg::*;

  function automatic logic [OUT_W-1:0] clamp_edge(input logic signed [CORNER_W-1:0] v,
                                                  input logic [OUT_W-1:0] lim);
    logic signed [CORNER_W-1:0] lim_s;
    lim_s = $signed(CORNER_W'(lim));
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] clamp_span(input logic [OUT_W-1:0] lo,
                                                  input logic [OUT_W-1:0] hi,
                                                  input logic [OUT_W-1:0] lim);
    logic signed [OUT_W:0] d;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    if (d < 0) begin
      return '0;
    end else if (d > $signed({1'b0, lim})) begin
      return lim;
    end
    return d[OUT_W-1:0];
  endfunction

  logic                       out_ready;
  logic [OUT_W-1:0]           wlim;
  logic [OUT_W-1:0]           hlim;
  logic signed [PROD_W-1:0]   wq;
  logic signed [PROD_W-1:0]   hq;
  logic signed [PROD_W-1:0]   xa;
  logic signed [PROD_W-1:0]   ya;
  logic signed [PROD_W-1:0]   xb;
  logic signed [PROD_W-1:0]   yb;
  logic                       norm_bad;

  logic                       s3_v_r;
  logic [OUT_W-1:0]           s3_x1_r;
  logic [OUT_W-1:0]           s3_y1_r;
  logic [OUT_W-1:0]           s3_x2_r;
  logic [OUT_W-1:0]           s3_y2_r;
  logic [CLASS_W-1:0]         s3_cls_r;
  logic [THR_W-1:0]           s3_score_r;

  logic [OUT_W-1:0]           w;
  logic [OUT_W-1:0]           h;
  logic                       size_ok;

  logic                       out_v_r;
  logic [OUT_W-1:0]           left_r;
  logic [OUT_W-1:0]           top_r;
  logic [OUT_W-1:0]           width_r;
  logic [OUT_W-1:0]           height_r;
  logic [CLASS_W-1:0]         cls_r;
  logic [THR_W-1:0]           conf_r;

  assign out_ready = !out_v_r || !out_stall;
  assign s3_ready  = !s3_v_r || out_ready;

  assign wlim = {cfg.net_w, 8'h00};
  assign hlim = {cfg.net_h, 8'h00};
  assign wq   = PROD_W'({cfg.net_w, 16'h0000});
  assign hq   = PROD_W'({cfg.net_h, 16'h0000});
  assign xa   = s2.xa;
  assign ya   = s2.ya;
  assign xb   = s2.xb;
  assign yb   = s2.yb;

  assign norm_bad = (xa >= xb) || (ya >= yb) || (xa < 0) || (ya < 0) ||
                    (xb > wq) || (yb > hq);

  // stage 3: validity checks, corners clamped to the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_valid && !(s2.norm && norm_bad);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_x1_r    <= clamp_edge($signed(xa[CORNER_W+7:8]), wlim);
      s3_y1_r    <= clamp_edge($signed(ya[CORNER_W+7:8]), hlim);
      s3_x2_r    <= clamp_edge($signed(xb[CORNER_W+7:8]), wlim);
      s3_y2_r    <= clamp_edge($signed(yb[CORNER_W+7:8]), hlim);
      s3_cls_r   <= s2.cls;
      s3_score_r <= s2.score;
    end
  end

  assign w       = clamp_span(s3_x1_r, s3_x2_r, wlim);
  assign h       = clamp_span(s3_y1_r, s3_y2_r, hlim);
  assign size_ok = (w >= MIN_SIZE) && (h >= MIN_SIZE);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s3_v_r && size_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_v_r) begin
      left_r   <= s3_x1_r;
      top_r    <= s3_y1_r;
      width_r  <= w;
      height_r <= h;
      cls_r    <= s3_cls_r;
      conf_r   <= s3_score_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_box_left   = left_r;
  assign out_box_top    = top_r;
  assign out_box_width  = width_r;
  assign out_box_height = height_r;
  assign out_class      = cls_r;
  assign out_confidence = conf_r;

  a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (width_r >= MIN_SIZE) && (height_r >= MIN_SIZE))
    else $error("box under one pixel on output");

  a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (({1'b0, left_r} + {1'b0, width_r}) <= {1'b0, wlim}) &&
                (({1'b0, top_r} + {1'b0, height_r}) <= {1'b0, hlim}))
    else $error("box leaves the frame");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !out_ready |=> s3_v_r)
    else $error("stage 3 beat lost under stall");

endmodule

// ----- rtl/detection_box_decode_filter.sv -----
// A kept candidate passes stage 1, stage 2, stage 3 and the output register in order.
// Throughput: one beat per cycle through four register stages (input and table read,
// multiply and format select, checks and clamp, span and output register);
// out_stall holds stages in place.
// Threshold writes and dropped candidates give no output beat.
// Reset (rst_n, synchronous, active low): format 0, 640 x 640 frame, every class
// threshold reads as zero.
`timescale 1ns / 1ps

module detection_box_decode_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic [dbdf_pkg::THR_W-1:0]            in_score,
  input  logic signed [dbdf_pkg::CLS_IN_W-1:0]  in_class_index,
  input  logic signed [dbdf_pkg::COORD_W-1:0]   in_coord_a,
  input  logic signed [dbdf_pkg::COORD_W-1:0]   in_coord_b,
  input  logic signed [dbdf_pkg::COORD_W-1:0]   in_coord_c,
  input  logic signed [dbdf_pkg::COORD_W-1:0]   in_coord_d,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dbdf_pkg::OUT_W-1:0]            out_box_left,
  output logic [dbdf_pkg::OUT_W-1:0]            out_box_top,
  output logic [dbdf_pkg::OUT_W-1:0]            out_box_width,
  output logic [dbdf_pkg::OUT_W-1:0]            out_box_height,
  output logic [dbdf_pkg::CLASS_W-1:0]          out_class,
  output logic [dbdf_pkg::THR_W-1:0]            out_confidence,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dbdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dbdf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dbdf_pkg::*;

  logic [FMT_W-1:0] box_format_r;
  logic [NET_W-1:0] net_width_r;
  logic [NET_W-1:0] net_height_r;
  dbdf_cfg_t        cfg;
  dbdf_tbl_req_t    tbl_req;
  logic [THR_W-1:0] thr;
  logic             s2_valid;
  dbdf_s2_t         s2;
  logic             s3_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_format_r <= FMT_RESET;
      net_width_r  <= NET_RESET;
      net_height_r <= NET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_FORMAT: box_format_r <= cfg_data[FMT_W-1:0];
        CFG_NET_WIDTH:  net_width_r  <= cfg_data[NET_W-1:0];
        CFG_NET_HEIGHT: net_height_r <= cfg_data[NET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.fmt   = box_format_r;
    cfg.net_w = net_width_r;
    cfg.net_h = net_height_r;
  end

  dbdf_thr_table u_thr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .thr   (thr)
  );

  dbdf_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_score       (in_score),
    .in_class_index (in_class_index),
    .in_coord_a     (in_coord_a),
    .in_coord_b     (in_coord_b),
    .in_coord_c     (in_coord_c),
    .in_coord_d     (in_coord_d),
    .tbl_req        (tbl_req),
    .thr            (thr),
    .s2_valid       (s2_valid),
    .s2             (s2),
    .s3_ready       (s3_ready)
  );

  dbdf_clamp u_clamp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .s2_valid       (s2_valid),
    .s2             (s2),
    .s3_ready       (s3_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_class      (out_class),
    .out_confidence (out_confidence)
  );

endmodule
